[hdl/jsu_pkg.sv]
// Shared types and constants for the JSON string unescaper.
// Result and result-group layouts, limit constants, hex digit decode.
// No dependencies.
package jsu_pkg;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_end;
    logic        truncated;
    logic [16:0] out_length;
    logic        last_of_run;
  } result_t;

  // up to four results caused by one input byte
  typedef struct packed {
    logic [2:0]        count;
    result_t [3:0]     item;
  } group_t;

  localparam logic [17:0] BUF_MAX   = 18'd131072;
  localparam logic [17:0] BUF_MIN   = 18'd5;
  localparam logic [17:0] BUF_SLACK = 18'd4;
  localparam logic [16:0] LIMIT_MAX = 17'd131068;

  function automatic logic [3:0] hex_value(input logic [7:0] h);
    logic [3:0] v;
    if (h >= 8'h30 && h <= 8'h39) begin
      v = 4'(h - 8'h30);
    end else if (h >= 8'h61 && h <= 8'h66) begin
      v = 4'(h - 8'h57);
    end else if (h >= 8'h41 && h <= 8'h46) begin
      v = 4'(h - 8'h37);
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

endpackage

[hdl/jsu_decode.sv]
// Escape decoder: scan state, hex accumulator, emitted count, UTF-8 encode.
// Turns one input byte into a group of up to four results.
// Depends on jsu_pkg.
module jsu_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          in_byte,
  input  logic                fire,
  input  logic [16:0]         limit,
  output jsu_pkg::group_t     group
);

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_HEX0   = 3'd2;
  localparam logic [2:0] MODE_HEX3   = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;

  logic [2:0]  scan_mode, scan_mode_next;
  logic [15:0] code_point, code_point_next;
  logic [16:0] emitted_count;

  logic        do_emit, use_lit, fin_forced, trunc_zero, check;
  logic [7:0]  lit_byte;
  logic [15:0] cp_enc, cp_shift;
  logic [1:0]  n;
  logic [7:0]  bytes [3];
  logic [17:0] count_sum;
  logic        reached, fin, trunc;
  logic [2:0]  total;

  assign cp_shift = {code_point[11:0], jsu_pkg::hex_value(in_byte)};

  always_comb begin
    scan_mode_next  = MODE_NORMAL;
    code_point_next = code_point;
    do_emit    = 1'b0;
    use_lit    = 1'b0;
    lit_byte   = in_byte;
    cp_enc     = code_point;
    fin_forced = 1'b0;
    trunc_zero = 1'b0;
    check      = 1'b0;
    unique case (scan_mode) inside
      MODE_ESC: begin
        if (in_byte == CH_NUL) begin
          do_emit    = 1'b1;
          use_lit    = 1'b1;
          lit_byte   = CH_BSL;
          fin_forced = 1'b1;
        end else if (in_byte == CH_U) begin
          scan_mode_next  = MODE_HEX0;
          code_point_next = 16'd0;
        end else begin
          do_emit = 1'b1;
          use_lit = 1'b1;
          check   = 1'b1;
          if (in_byte == CH_N) lit_byte = CH_LF;
          else if (in_byte == CH_T) lit_byte = CH_TAB;
        end
      end
      [MODE_HEX0:MODE_HEX3]: begin
        if (in_byte == CH_NUL) begin
          do_emit    = 1'b1;
          fin_forced = 1'b1;
        end else if (scan_mode == MODE_HEX3) begin
          do_emit         = 1'b1;
          cp_enc          = cp_shift;
          code_point_next = 16'd0;
          check           = 1'b1;
        end else begin
          scan_mode_next  = scan_mode + 3'd1;
          code_point_next = cp_shift;
        end
      end
      default: begin
        if (in_byte == CH_NUL || in_byte == CH_QUOTE) begin
          fin_forced = 1'b1;
          trunc_zero = 1'b1;
        end else if (in_byte == CH_BSL) begin
          scan_mode_next = MODE_ESC;
        end else begin
          do_emit = 1'b1;
          use_lit = 1'b1;
          check   = 1'b1;
        end
      end
    endcase
  end

  // byte sequence for the decoded character
  always_comb begin
    bytes[0] = 8'h00;
    bytes[1] = 8'h00;
    bytes[2] = 8'h00;
    n = 2'd0;
    if (do_emit) begin
      if (use_lit) begin
        n = 2'd1;
        bytes[0] = lit_byte;
      end else if (cp_enc < 16'h0080) begin
        n = 2'd1;
        bytes[0] = cp_enc[7:0];
      end else if (cp_enc < 16'h0800) begin
        n = 2'd2;
        bytes[0] = 8'hC0 | {3'b000, cp_enc[10:6]};
        bytes[1] = 8'h80 | {2'b00, cp_enc[5:0]};
      end else begin
        n = 2'd3;
        bytes[0] = 8'hE0 | {4'h0, cp_enc[15:12]};
        bytes[1] = 8'h80 | {2'b00, cp_enc[11:6]};
        bytes[2] = 8'h80 | {2'b00, cp_enc[5:0]};
      end
    end
  end

  assign count_sum = {1'b0, emitted_count} + {16'd0, n};
  assign reached   = count_sum >= {1'b0, limit};
  assign fin       = fin_forced || (check && reached);
  assign trunc     = fin_forced ? (!trunc_zero && reached) : 1'b1;
  assign total     = {1'b0, n} + {2'b00, fin};

  always_comb begin
    group.count = total;
    for (int i = 0; i < 4; i++) begin
      group.item[i] = '0;
      if (i < 3 && 2'(i) < n) begin
        group.item[i].out_byte = bytes[i < 3 ? i : 0];
      end else if (fin && 3'(i) == {1'b0, n}) begin
        group.item[i].is_end     = 1'b1;
        group.item[i].truncated  = trunc;
        group.item[i].out_length = count_sum[16:0];
      end
      group.item[i].last_of_run = (3'(i) + 3'd1 == total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_NORMAL;
      code_point    <= 16'd0;
      emitted_count <= 17'd0;
    end else if (fire) begin
      if (fin) begin
        scan_mode     <= MODE_NORMAL;
        code_point    <= 16'd0;
        emitted_count <= 17'd0;
      end else begin
        scan_mode     <= scan_mode_next;
        code_point    <= code_point_next;
        emitted_count <= count_sum[16:0];
      end
    end
  end

endmodule

[hdl/jsu_out_queue.sv]
// Result register: holds a group and hands out one per cycle with m_ready.
// Takes a new group on the cycle the last result of the old one is taken.
// Depends on jsu_pkg.
module jsu_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  jsu_pkg::group_t   load_group,
  input  logic              load_req,
  output logic              load_ok,
  output logic              m_valid,
  input  logic              m_ready,
  output jsu_pkg::result_t  result
);

  jsu_pkg::group_t grp;
  logic [1:0] idx;
  logic       busy;
  logic [2:0] cnt_m1;
  logic       idx_last, take;

  assign cnt_m1   = grp.count - 3'd1;
  assign idx_last = (idx == cnt_m1[1:0]);
  assign take     = busy && m_ready;
  assign load_ok  = !busy || (take && idx_last);
  assign m_valid  = busy;
  assign result   = grp.item[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load_req) begin
      busy <= (load_group.count != 3'd0);
      idx  <= 2'd0;
    end else if (take) begin
      if (idx_last) busy <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_req) grp <= load_group;
  end

endmodule

[hdl/json_string_unescape_utf8_core.sv]
// Top level of the JSON string unescaper with UTF-8 output.
// Holds the input register and the buffer limit register.
// Depends on jsu_pkg, jsu_decode, jsu_out_queue.
//
// Usage: raw string-body bytes enter on s_tvalid/s_tready/s_tdata, one
// byte per request. Decoded bytes and one end result per string leave on
// m_tvalid/m_tready. m_tuser marks the end result of a string, which
// carries the length and the truncated flag; m_tlast marks the final
// result caused by one input byte. An input byte gives zero to four results.
// A byte waits in the input register until the result register takes its group;
// its first result is then offered from the result register.
// Throughput: one byte per cycle while each byte gives at most one result and
// m_tready is high; a byte with more results holds the result register until
// all are taken; the single output register drains one result per cycle while ready.
// Bytes that give no result (backslash, u, leading hex digits) load an empty group.
// While the receiver stalls, one byte still enters the input register;
// then s_tready drops until the result register frees.
// Reset: scan state, count and queue clear; the limit register returns to
// a buffer of 131072 bytes. cfg_wr_en writes the buffer size at once.
module json_string_unescape_utf8_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,     // [7:0] out_byte, [8] truncated, [25:9] out_length
  output logic        m_tlast,     // last_of_run
  output logic        m_tuser,     // is_end
  input  logic        cfg_wr_en,
  input  logic [17:0] cfg_wr_data
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic [16:0] limit;
  logic        load_ok, consume;
  jsu_pkg::group_t  group;
  jsu_pkg::result_t result;
  logic [17:0] limit_calc;

  assign consume  = in_valid && load_ok;
  assign s_tready = !in_valid || load_ok;

  // clamp to the largest buffer; too-small buffers end after one character
  always_comb begin
    if (cfg_wr_data > jsu_pkg::BUF_MAX) begin
      limit_calc = {1'b0, jsu_pkg::LIMIT_MAX};
    end else if (cfg_wr_data >= jsu_pkg::BUF_MIN) begin
      limit_calc = cfg_wr_data - jsu_pkg::BUF_SLACK;
    end else begin
      limit_calc = 18'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= jsu_pkg::LIMIT_MAX;
    end else if (cfg_wr_en) begin
      limit <= limit_calc[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_byte <= s_tdata;
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .in_byte (in_byte),
    .fire    (consume),
    .limit   (limit),
    .group   (group)
  );

  jsu_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .load_group (group),
    .load_req   (consume),
    .load_ok    (load_ok),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .result     (result)
  );

  assign m_tdata = {6'd0, result.out_length, result.truncated, result.out_byte};
  assign m_tlast = result.last_of_run;
  assign m_tuser = result.is_end;

endmodule

[bench/tb_top.sv]
// Self-checking bench for json_string_unescape_utf8_core: directed table then random strings.
// Predicts escapes, \u to UTF-8, string ends and buffer-limit cuts; checks every result.
// Depends on jsu_pkg (result layout, buffer constants) and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_U = 8'h75;

  localparam int RANDOM_BYTES = 95;
  localparam int HOLD_CYCLES  = 80;

  typedef enum logic [2:0] {
    SCAN_NORMAL, SCAN_ESC, SCAN_HEX0, SCAN_HEX1, SCAN_HEX2, SCAN_HEX3
  } scan_mode_e;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [17:0]      value;
    bit               typed;
    jsu_pkg::result_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [17:0] cfg_wr_data = 18'd0;

  json_string_unescape_utf8_core dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),      // [7:0] in_byte
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),      // [7:0] out_byte, [8] truncated, [25:9] out_length
    .m_tlast    (m_tlast),      // last_of_run
    .m_tuser    (m_tuser),      // is_end
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // unescaper state as the block should hold it
  scan_mode_e  scan_state = SCAN_NORMAL;
  logic [15:0] cp_acc = 16'h0000;
  logic [16:0] emit_count = 17'd0;
  logic [17:0] buf_size = jsu_pkg::BUF_MAX;

  jsu_pkg::result_t step_results[$];
  jsu_pkg::result_t pending_results[$];

  int fail_count = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int ends_seen = 0;
  int cuts_seen = 0;
  int cfg_writes = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c[3:0];
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic logic [16:0] count_limit();
    logic [17:0] s;
    s = (buf_size > jsu_pkg::BUF_MAX) ? jsu_pkg::BUF_MAX : buf_size;
    return (s > jsu_pkg::BUF_SLACK) ? 17'(s - jsu_pkg::BUF_SLACK) : 17'd0;
  endfunction

  // an end result carries the count and clears the string state
  function automatic void put_result(input logic [7:0] b, input bit fin, input bit cut);
    step_results.push_back('{out_byte: fin ? 8'h00 : b, is_end: fin, truncated: cut,
                             out_length: fin ? emit_count : 17'd0, last_of_run: 1'b0});
    if (fin) begin
      scan_state = SCAN_NORMAL;
      cp_acc = 16'h0000;
      emit_count = 17'd0;
    end else begin
      emit_count = emit_count + 17'd1;
    end
  endfunction

  function automatic void put_char(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      put_result(cp[7:0], 1'b0, 1'b0);
    end else if (cp < 16'h0800) begin
      put_result({3'b110, cp[10:6]}, 1'b0, 1'b0);
      put_result({2'b10, cp[5:0]}, 1'b0, 1'b0);
    end else begin
      put_result({4'hE, cp[15:12]}, 1'b0, 1'b0);
      put_result({2'b10, cp[11:6]}, 1'b0, 1'b0);
      put_result({2'b10, cp[5:0]}, 1'b0, 1'b0);
    end
  endfunction

  function automatic void limit_check();
    if (emit_count >= count_limit()) put_result(8'h00, 1'b1, 1'b1);
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    step_results.delete();
    case (scan_state)
      SCAN_ESC: begin
        if (b == CH_NUL) begin
          put_result(CH_BSLASH, 1'b0, 1'b0);
          put_result(8'h00, 1'b1, emit_count >= count_limit());
        end else if (b == CH_LOWER_U) begin
          scan_state = SCAN_HEX0;
          cp_acc = 16'h0000;
        end else begin
          scan_state = SCAN_NORMAL;
          put_result((b == CH_LOWER_N) ? CH_LF : (b == CH_LOWER_T) ? CH_TAB : b, 1'b0, 1'b0);
          limit_check();
        end
      end
      SCAN_HEX0, SCAN_HEX1, SCAN_HEX2, SCAN_HEX3: begin
        if (b == CH_NUL) begin
          put_char(cp_acc);
          put_result(8'h00, 1'b1, emit_count >= count_limit());
        end else begin
          cp_acc = {cp_acc[11:0], nibble_of(b)};
          if (scan_state == SCAN_HEX3) begin
            scan_state = SCAN_NORMAL;
            put_char(cp_acc);
            cp_acc = 16'h0000;
            limit_check();
          end else begin
            scan_state = scan_mode_e'(scan_state + 3'd1);
          end
        end
      end
      default: begin
        scan_state = SCAN_NORMAL;
        if (b == CH_NUL || b == CH_QUOTE) begin
          put_result(8'h00, 1'b1, 1'b0);
        end else if (b == CH_BSLASH) begin
          scan_state = SCAN_ESC;
        end else begin
          put_result(b, 1'b0, 1'b0);
          limit_check();
        end
      end
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic row_t op(input row_kind_e k, input logic [17:0] v);
    return '{kind: k, value: v, typed: 1'b0, want: '0};
  endfunction

  function automatic row_t op_byte(input logic [7:0] b);
    return '{kind: ROW_BYTE, value: 18'(b), typed: 1'b0, want: '0};
  endfunction

  function automatic row_t op_known(input logic [7:0] b, input jsu_pkg::result_t w);
    return '{kind: ROW_BYTE, value: 18'(b), typed: 1'b1, want: w};
  endfunction

  function automatic jsu_pkg::result_t data_res(input logic [7:0] b);
    return '{out_byte: b, is_end: 1'b0, truncated: 1'b0, out_length: 17'd0, last_of_run: 1'b1};
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  // sender: bursts of random length, random gaps between them
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input jsu_pkg::result_t want = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    decode_byte(b);
    if (typed) pending_results.push_back(want);
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  // register writes only with nothing in flight; bytes with no result may still be inside
  task automatic set_buf_size(input logic [17:0] v);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    buf_size = v;
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [16:0] want_v,
                             input logic [16:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    jsu_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: byte %0h end %b", m_tdata[7:0], m_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_byte", 17'(want.out_byte), 17'(m_tdata[7:0]));
        check_field("is_end", 17'(want.is_end), 17'(m_tuser));
        check_field("truncated", 17'(want.truncated), 17'(m_tdata[8]));
        check_field("out_length", want.out_length, m_tdata[25:9]);
        check_field("last_of_run", 17'(want.last_of_run), 17'(m_tlast));
        if (want.is_end) begin
          ends_seen++;
          if (want.truncated) cuts_seen++;
        end
      end
    end
  end

  // receiver: rotating stall pattern, plus one long hold-off on request
  initial begin
    int tick;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      tick++;
      case ((tick / 64) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        2: m_tready <= (tick % 3 != 0);
        default: m_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    #200_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    row_t plan[$];
    logic [17:0] sizes[8];
    int directed_bytes;
    int phase;
    int phase_end;
    int r;
    int k;
    int drain;
    logic [7:0] b;

    sizes = '{18'd5, 18'd262143, 18'd0, 18'd131072, 18'd7, 18'd4, 18'd131073, 18'd24};

    // default buffer: plain bytes, single-character escapes, then a quote closes the string
    plan.push_back(op_known("A", data_res("A")));
    plan.push_back(op_known(8'hFF, data_res(8'hFF)));
    plan.push_back(op_byte(CH_BSLASH));
    plan.push_back(op_known(CH_LOWER_N, data_res(CH_LF)));
    plan.push_back(op_byte(CH_BSLASH));
    plan.push_back(op_known(CH_LOWER_T, data_res(CH_TAB)));
    plan.push_back(op_byte(CH_BSLASH));
    plan.push_back(op_byte(CH_QUOTE));
    plan.push_back(op_byte(CH_BSLASH));
    plan.push_back(op_byte(CH_BSLASH));
    plan.push_back(op_byte(CH_BSLASH));
    plan.push_back(op_byte(CH_SLASH));
    plan.push_back(op_byte(CH_BSLASH));
    plan.push_back(op_byte(CH_LOWER_B));
    plan.push_back(op_known(CH_QUOTE, '{out_byte: 8'h00, is_end: 1'b1, truncated: 1'b0,
                                       out_length: 17'd8, last_of_run: 1'b1}));
    // limit 2: three-byte char with a quote as a digit overshoots and cuts
    plan.push_back(op(ROW_CFG, 18'd6));
    plan.push_back(op_byte(CH_BSLASH));
    plan.push_back(op_byte(CH_LOWER_U));
    plan.push_back(op_byte("2"));
    plan.push_back(op_byte(CH_QUOTE));
    plan.push_back(op_byte("A"));
    plan.push_back(op_byte("C"));
    // backslash then NUL
    plan.push_back(op_byte(CH_BSLASH));
    plan.push_back(op_byte(CH_NUL));
    // size below the minimum: limit 0; NUL inside \u after two digits and after none
    plan.push_back(op(ROW_CFG, 18'd0));
    plan.push_back(op_byte(CH_BSLASH));
    plan.push_back(op_byte(CH_LOWER_U));
    plan.push_back(op_byte("e"));
    plan.push_back(op_byte("9"));
    plan.push_back(op_byte(CH_NUL));
    plan.push_back(op_byte(CH_BSLASH));
    plan.push_back(op_byte(CH_LOWER_U));
    plan.push_back(op_byte(CH_NUL));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) set_buf_size(plan[i].value);
      else send_byte(plan[i].value[7:0], plan[i].typed, plan[i].want);
    end
    directed_bytes = bytes_sent;

    // random phases; the size changes between them, often mid-string
    phase = 0;
    while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
      set_buf_size((phase < 8) ? sizes[phase] : 18'($urandom_range(5, 64)));
      if (phase == 1) hold_request = 1'b1;
      phase_end = bytes_sent + $urandom_range(12, 22);
      while (bytes_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          b = 8'($urandom_range(1, 255));
          if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h40;
          send_byte(b);
        end else if (r < 60) begin
          send_byte(CH_BSLASH);
          case ($urandom_range(0, 7))
            0: send_byte(CH_LOWER_N);
            1: send_byte(CH_LOWER_T);
            2: send_byte(CH_QUOTE);
            3: send_byte(CH_BSLASH);
            4: send_byte(CH_SLASH);
            5: send_byte(CH_LOWER_B);
            default: send_byte(8'($urandom_range(1, 255)));
          endcase
        end else if (r < 80) begin
          send_byte(CH_BSLASH);
          send_byte(CH_LOWER_U);
          for (int d = 0; d < 4; d++) begin
            if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(1, 255));
            else if (d < 2 && $urandom_range(0, 2) == 0) b = "0";
            else b = hex_char();
            send_byte(b);
          end
        end else if (r < 88) begin
          send_byte(CH_QUOTE);
        end else if (r < 92) begin
          send_byte(CH_NUL);
        end else if (r < 95) begin
          send_byte(CH_BSLASH);
          send_byte(CH_NUL);
        end else if (r < 98) begin
          send_byte(CH_BSLASH);
          send_byte(CH_LOWER_U);
          k = $urandom_range(0, 3);
          repeat (k) send_byte(hex_char());
          send_byte(CH_NUL);
        end else begin
          send_byte(8'($urandom_range(0, 255)));
        end
      end
      phase++;
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes (%0d from the table); checked %0d results, %0d string ends,",
             bytes_sent, directed_bytes, results_seen, ends_seen);
    $display("%0d of them cut at the buffer limit, across %0d buffer size writes.",
             cuts_seen, cfg_writes);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
